@@ rtl/assert_macros.svh @@
// Assertion macros of the token lexer, used by its top level.
// Included by the files that assert; expands to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/tls_pkg.sv @@
// Types, constants and scanning functions of the token lexer.
// Used by every module of the block; depends on nothing else.
package tls_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LENGTH_BITS = 16;
   localparam int MAX_TOKENS = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_BITS = $clog2(MAX_TOKENS + 1);
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QLVL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int TOKEN_BITS = 4 + OFFSET_BITS + LENGTH_BITS;
   localparam int TDATA_BITS = ((TOKEN_BITS + 7) / 8) * 8;
   localparam int NUM_WORDS = 17;
   localparam int CAND_COUNT = 8;

   typedef enum logic [3:0] {
      CLS_EOF = 4'd0, CLS_INVALID = 4'd1, CLS_INT = 4'd2, CLS_DEC = 4'd3,
      CLS_SYM = 4'd4, CLS_KEY = 4'd5, CLS_PRIM = 4'd6, CLS_ADD = 4'd7,
      CLS_MUL = 4'd8, CLS_CMP = 4'd9, CLS_POST = 4'd10, CLS_SPEC = 4'd11,
      CLS_GROUP = 4'd12
   } token_class_type;

   typedef enum logic [13:0] {
      MODE_IDLE     = 14'b00000000000001,
      MODE_MINUS    = 14'b00000000000010,
      MODE_INT      = 14'b00000000000100,
      MODE_DOT_INT  = 14'b00000000001000,
      MODE_FRAC     = 14'b00000000010000,
      MODE_EXP      = 14'b00000000100000,
      MODE_EXP_SIGN = 14'b00000001000000,
      MODE_EXP_DIG  = 14'b00000010000000,
      MODE_SYM      = 14'b00000100000000,
      MODE_PRIME    = 14'b00001000000000,
      MODE_BANG     = 14'b00010000000000,
      MODE_LTGT     = 14'b00100000000000,
      MODE_EQ       = 14'b01000000000000,
      MODE_DOT      = 14'b10000000000000
   } scan_mode_type;

   typedef enum logic [1:0] {
      ACT_DONE = 2'd0, ACT_RESCAN = 2'd1, ACT_PUSHBACK = 2'd2
   } action_type;

   typedef struct packed {
      token_class_type             cls;
      logic [OFFSET_BITS-1:0]      start;
      logic [LENGTH_BITS-1:0]      len;
   } token_type;

   typedef struct packed {
      token_type [MAX_TOKENS-1:0]  toks;
      logic [COUNT_BITS-1:0]       count;
   } bundle_type;

   typedef struct packed {
      logic                        full;
      logic                        empty;
   } queue_status_type;

   typedef struct packed {
      scan_mode_type               mode;
      logic                        comment;
      logic [OFFSET_BITS-1:0]      tstart;
      logic [LENGTH_BITS-1:0]      len;
      logic [7:0]                  pb0;
      logic [7:0]                  pb1;
      logic                        base_dec;
      logic [4:0][7:0]             word;
      logic                        err;
   } scan_state_type;

   typedef struct packed {
      scan_state_type              st;
      logic                        emit;
      token_type                   tok;
      action_type                  action;
   } step_type;

   typedef struct packed {
      scan_state_type              st;
      logic                        emit0;
      token_type                   tok0;
      logic                        emit1;
      token_type                   tok1;
   } pair_type;

   localparam logic [39:0] WORD_TEXT [NUM_WORDS] = '{
      "for", "all", "some", "if", "then", "else", "such", "that", "in", "and",
      "or", "with", "true", "false", "nil", "pass", "stop"};
   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
      3'd3, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3,
      3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd4, 3'd4};
   localparam logic WORD_PRIM [NUM_WORDS] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

   localparam logic [8:0] END_MARK = 9'h100;

   function automatic logic is_digit(logic [8:0] c);
      return !c[8] && c[7:0] >= "0" && c[7:0] <= "9";
   endfunction

   function automatic logic is_alpha(logic [8:0] c);
      return !c[8] && (c[7:0] == "_" || (c[7:0] >= "a" && c[7:0] <= "z") ||
                       (c[7:0] >= "A" && c[7:0] <= "Z"));
   endfunction

   function automatic logic is_char(logic [8:0] c, logic [7:0] ch);
      return !c[8] && c[7:0] == ch;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_add(logic [LENGTH_BITS-1:0] a,
                                                      logic [1:0] b);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + (LENGTH_BITS + 1)'(b);
      return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
   endfunction

   // Unprimed symbols of up to five bytes are looked up in the word list.
   function automatic token_class_type word_class(logic [4:0][7:0] word,
                                                  logic [LENGTH_BITS-1:0] len);
      token_class_type cls;
      logic same;
      int idx;
      cls = CLS_SYM;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         same = (len == LENGTH_BITS'(WORD_LEN[i]));
         for (int k = 0; k < 5; k++) begin
            idx = int'(WORD_LEN[i]) - 1 - k;
            if (k < int'(WORD_LEN[i]) && word[k] != WORD_TEXT[i][idx*8 +: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            cls = WORD_PRIM[i] ? CLS_PRIM : CLS_KEY;
         end
      end
      return cls;
   endfunction

   function automatic token_type make_token(token_class_type cls,
                                            logic [OFFSET_BITS-1:0] start,
                                            logic [LENGTH_BITS-1:0] len);
      token_type t;
      t.cls = cls;
      t.start = start;
      t.len = len;
      return t;
   endfunction

   // One scanning step of byte c (or the end mark) at offset p.
   function automatic step_type scan_step(scan_state_type s, logic [8:0] c,
                                          logic [OFFSET_BITS-1:0] p);
      step_type r;
      logic dig;
      r.st = s;
      r.st.mode = MODE_IDLE;
      r.emit = 1'b0;
      r.tok = make_token(CLS_INVALID, s.tstart, s.len);
      r.action = ACT_DONE;
      dig = is_digit(c);
      unique case (s.mode) inside
         MODE_MINUS: begin
            if (dig) begin
               r.st.mode = MODE_INT;
               r.st.len = sat_add(s.len, 2'd1);
            end else begin
               r.emit = 1'b1;
               r.tok.cls = CLS_ADD;
               r.action = ACT_RESCAN;
            end
         end
         MODE_INT, MODE_FRAC, MODE_EXP_DIG: begin
            if (dig) begin
               r.st.mode = s.mode;
               r.st.len = sat_add(s.len, 2'd1);
            end else if (s.mode != MODE_EXP_DIG && (is_char(c, "e") || is_char(c, "E")))
            begin
               r.st.base_dec = (s.mode != MODE_INT);
               r.st.pb0 = c[7:0];
               r.st.mode = MODE_EXP;
            end else if (s.mode == MODE_INT && is_char(c, ".")) begin
               r.st.pb0 = c[7:0];
               r.st.mode = MODE_DOT_INT;
            end else begin
               r.emit = 1'b1;
               r.tok.cls = (s.mode == MODE_INT) ? CLS_INT : CLS_DEC;
               r.action = ACT_RESCAN;
            end
         end
         MODE_DOT_INT, MODE_EXP_SIGN: begin
            if (dig) begin
               r.st.len = sat_add(s.len, (s.mode == MODE_DOT_INT) ? 2'd2 : 2'd3);
               r.st.mode = (s.mode == MODE_DOT_INT) ? MODE_FRAC : MODE_EXP_DIG;
            end else begin
               r.emit = 1'b1;
               r.tok.cls = (s.mode == MODE_DOT_INT || !s.base_dec) ? CLS_INT : CLS_DEC;
               r.action = ACT_PUSHBACK;
            end
         end
         MODE_EXP: begin
            if (is_char(c, "+") || is_char(c, "-")) begin
               r.st.pb1 = c[7:0];
               r.st.mode = MODE_EXP_SIGN;
            end else if (dig) begin
               r.st.len = sat_add(s.len, 2'd2);
               r.st.mode = MODE_EXP_DIG;
            end else begin
               r.emit = 1'b1;
               r.tok.cls = s.base_dec ? CLS_DEC : CLS_INT;
               r.action = ACT_PUSHBACK;
            end
         end
         MODE_SYM: begin
            if (is_alpha(c) || dig) begin
               if (s.len < LENGTH_BITS'(4)) begin
                  r.st.word[s.len[1:0]] = c[7:0];
               end else if (s.len == LENGTH_BITS'(4)) begin
                  r.st.word[4] = c[7:0];
               end
               r.st.len = sat_add(s.len, 2'd1);
               r.st.mode = MODE_SYM;
            end else if (is_char(c, "'")) begin
               r.st.len = sat_add(s.len, 2'd1);
               r.st.mode = MODE_PRIME;
            end else begin
               r.emit = 1'b1;
               r.tok.cls = (s.len <= LENGTH_BITS'(5)) ? word_class(s.word, s.len) : CLS_SYM;
               r.action = ACT_RESCAN;
            end
         end
         MODE_PRIME: begin
            if (is_char(c, "'")) begin
               r.st.len = sat_add(s.len, 2'd1);
               r.st.mode = MODE_PRIME;
            end else begin
               r.emit = 1'b1;
               r.tok.cls = CLS_SYM;
               r.action = ACT_RESCAN;
            end
         end
         MODE_BANG, MODE_LTGT, MODE_EQ: begin
            r.emit = 1'b1;
            if (is_char(c, "=")) begin
               r.tok.cls = CLS_CMP;
               r.tok.len = LENGTH_BITS'(2);
            end else begin
               r.tok.cls = (s.mode == MODE_BANG) ? CLS_POST :
                           (s.mode == MODE_EQ) ? CLS_SPEC : CLS_CMP;
               r.tok.len = LENGTH_BITS'(1);
               r.action = ACT_RESCAN;
            end
         end
         MODE_DOT: begin
            r.emit = 1'b1;
            if (is_char(c, ".")) begin
               r.tok.cls = CLS_SPEC;
               r.tok.len = LENGTH_BITS'(2);
            end else begin
               r.tok.cls = CLS_INVALID;
               r.tok.len = LENGTH_BITS'(1);
               r.action = ACT_RESCAN;
            end
         end
         default: begin
            r.tok = make_token(CLS_INVALID, p, LENGTH_BITS'(1));
            if (s.comment) begin
               if (is_char(c, 8'h0A)) begin
                  r.st.comment = 1'b0;
               end
            end else if (c == END_MARK || is_char(c, " ") || is_char(c, 8'h09) ||
                         is_char(c, 8'h0A) || is_char(c, 8'h0D) || is_char(c, 8'h0B))
            begin
               r.st.comment = 1'b0;
            end else if (is_char(c, "#")) begin
               r.st.comment = 1'b1;
            end else if (dig || is_alpha(c) || is_char(c, "-") || is_char(c, "!") ||
                         is_char(c, "<") || is_char(c, ">") || is_char(c, "=") ||
                         is_char(c, ".")) begin
               r.st.tstart = p;
               r.st.len = LENGTH_BITS'(1);
               r.st.word[0] = c[7:0];
               if (dig) r.st.mode = MODE_INT;
               else if (is_alpha(c)) r.st.mode = MODE_SYM;
               else if (is_char(c, "-")) r.st.mode = MODE_MINUS;
               else if (is_char(c, "!")) r.st.mode = MODE_BANG;
               else if (is_char(c, "=")) r.st.mode = MODE_EQ;
               else if (is_char(c, ".")) r.st.mode = MODE_DOT;
               else r.st.mode = MODE_LTGT;
            end else begin
               r.emit = 1'b1;
               case (c[7:0]) inside
                  "+": r.tok.cls = CLS_ADD;
                  "*", "/", "%": r.tok.cls = CLS_MUL;
                  "?": r.tok.cls = CLS_POST;
                  ",", ":", "\\": r.tok.cls = CLS_SPEC;
                  "(", ")", "[", "]", "{", "}": r.tok.cls = CLS_GROUP;
                  default: begin
                     r.tok.cls = CLS_INVALID;
                     r.tok.len = '0;
                     r.st.err = 1'b1;
                  end
               endcase
            end
         end
      endcase
      return r;
   endfunction

   // A byte scanned once, and again from idle when the pending token ended at it.
   function automatic pair_type scan_byte(scan_state_type s, logic [8:0] c,
                                          logic [OFFSET_BITS-1:0] p);
      step_type x;
      step_type y;
      pair_type r;
      x = scan_step(s, c, p);
      r.st = x.st;
      r.emit0 = x.emit;
      r.tok0 = x.tok;
      r.emit1 = 1'b0;
      r.tok1 = x.tok;
      if (x.action == ACT_RESCAN) begin
         y = scan_step(x.st, c, p);
         r.st = y.st;
         r.emit1 = y.emit;
         r.tok1 = y.tok;
      end
      return r;
   endfunction

endpackage

@@ rtl/tls_front.sv @@
// Front end of the token lexer: takes one byte transaction per cycle while the
// queue is not full and scans it into a bundle of tokens. Depends on tls_pkg.
module tls_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       in_kind,
   input  logic [7:0]                 in_byte,
   output logic                       in_ready,
   input  tls_pkg::queue_status_type  q_status,
   output logic                       push,
   output tls_pkg::bundle_type        bundle
);

   tls_pkg::scan_state_type                state_ff, state_in;
   logic [tls_pkg::OFFSET_BITS-1:0]        pos_ff, pos_in;
   tls_pkg::step_type                      first_step;
   tls_pkg::step_type                      rescan_step;
   tls_pkg::pair_type                      pb_a, pb_b, last_byte;
   logic [8:0]                             cur;
   logic [tls_pkg::OFFSET_BITS-1:0]        pb_pos;
   logic                                   cand_v [tls_pkg::CAND_COUNT];
   tls_pkg::token_type                     cand_t [tls_pkg::CAND_COUNT];
   logic [tls_pkg::COUNT_BITS-1:0]         n;
   logic                                   accept;

   assign in_ready = !q_status.full;
   assign accept = in_valid && in_ready;

   always_comb begin
      cur = in_kind ? tls_pkg::END_MARK : {1'b0, in_byte};
      pb_pos = (state_ff.mode == tls_pkg::MODE_EXP_SIGN) ?
               pos_ff - tls_pkg::OFFSET_BITS'(2) : pos_ff - tls_pkg::OFFSET_BITS'(1);
      first_step = tls_pkg::scan_step(state_ff, cur, pos_ff);
      rescan_step = tls_pkg::scan_step(first_step.st, cur, pos_ff);
      // Backed-off suffix bytes are scanned again from idle, then the new byte.
      pb_a = tls_pkg::scan_byte(first_step.st, {1'b0, state_ff.pb0}, pb_pos);
      if (state_ff.mode == tls_pkg::MODE_EXP_SIGN) begin
         pb_b = tls_pkg::scan_byte(pb_a.st, {1'b0, state_ff.pb1},
                                   pos_ff - tls_pkg::OFFSET_BITS'(1));
      end else begin
         pb_b = pb_a;
         pb_b.emit0 = 1'b0;
         pb_b.emit1 = 1'b0;
      end
      last_byte = tls_pkg::scan_byte(pb_b.st, cur, pos_ff);

      for (int i = 0; i < tls_pkg::CAND_COUNT; i++) begin
         cand_v[i] = 1'b0;
         cand_t[i] = first_step.tok;
      end
      state_in = first_step.st;
      cand_v[0] = first_step.emit;
      case (first_step.action)
         tls_pkg::ACT_RESCAN: begin
            cand_v[1] = rescan_step.emit;
            cand_t[1] = rescan_step.tok;
            state_in = rescan_step.st;
         end
         tls_pkg::ACT_PUSHBACK: begin
            cand_v[1] = pb_a.emit0;       cand_t[1] = pb_a.tok0;
            cand_v[2] = pb_a.emit1;       cand_t[2] = pb_a.tok1;
            cand_v[3] = pb_b.emit0;       cand_t[3] = pb_b.tok0;
            cand_v[4] = pb_b.emit1;       cand_t[4] = pb_b.tok1;
            cand_v[5] = last_byte.emit0;  cand_t[5] = last_byte.tok0;
            cand_v[6] = last_byte.emit1;  cand_t[6] = last_byte.tok1;
            state_in = last_byte.st;
         end
         default: begin
         end
      endcase
      if (state_ff.err) begin
         state_in = state_ff;
         for (int i = 0; i < tls_pkg::CAND_COUNT - 1; i++) begin
            cand_v[i] = 1'b0;
         end
      end
      cand_v[tls_pkg::CAND_COUNT-1] = in_kind;
      cand_t[tls_pkg::CAND_COUNT-1] =
         tls_pkg::make_token(tls_pkg::CLS_EOF, pos_ff, '0);
      if (in_kind) begin
         state_in.mode = tls_pkg::MODE_IDLE;
         state_in.comment = 1'b0;
      end
      pos_in = in_kind ? pos_ff : pos_ff + tls_pkg::OFFSET_BITS'(1);

      // Pack the emitted tokens in order, dropping any beyond the bundle size.
      n = '0;
      bundle.toks = '0;
      for (int i = 0; i < tls_pkg::CAND_COUNT; i++) begin
         if (cand_v[i] && n < tls_pkg::COUNT_BITS'(tls_pkg::MAX_TOKENS)) begin
            bundle.toks[n[tls_pkg::QPTR_BITS-1:0]] = cand_t[i];
            n = n + tls_pkg::COUNT_BITS'(1);
         end
      end
      bundle.count = n;
   end

   assign push = accept && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= tls_pkg::MODE_IDLE;
         state_ff.comment <= 1'b0;
         state_ff.err <= 1'b0;
         state_ff.tstart <= '0;
         state_ff.len <= '0;
         state_ff.pb0 <= '0;
         state_ff.pb1 <= '0;
         state_ff.base_dec <= 1'b0;
         state_ff.word <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         pos_ff <= pos_in;
      end
   end

endmodule

@@ rtl/tls_queue.sv @@
// Token bundle queue between the front and back ends of the token lexer.
// Depends on tls_pkg.
module tls_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tls_pkg::bundle_type        push_bundle,
   input  logic                       pop,
   output tls_pkg::bundle_type        head,
   output tls_pkg::queue_status_type  status,
   output logic [tls_pkg::QLVL_BITS-1:0] level
);

   tls_pkg::bundle_type                  entry_ff [tls_pkg::QUEUE_DEPTH];
   logic [tls_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tls_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tls_pkg::QLVL_BITS-1:0]        level_ff, level_in;

   assign head = entry_ff[rd_ptr_ff];
   assign status.full = (level_ff == tls_pkg::QLVL_BITS'(tls_pkg::QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign level = level_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tls_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + tls_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      level_in = level_ff + tls_pkg::QLVL_BITS'(push) - tls_pkg::QLVL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

@@ rtl/tls_back.sv @@
// Back end of the token lexer: hands out the tokens of the head bundle one
// transaction per cycle while out_ready is high. Depends on tls_pkg.
module tls_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tls_pkg::bundle_type        head,
   input  tls_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [tls_pkg::TDATA_BITS-1:0] out_data,
   output logic                       out_last
);

   logic [tls_pkg::QPTR_BITS-1:0]  idx_ff, idx_in;
   tls_pkg::token_type             tok;

   assign tok = head.toks[idx_ff];
   assign out_valid = !q_status.empty;
   assign out_last = (tls_pkg::COUNT_BITS'(idx_ff) + tls_pkg::COUNT_BITS'(1) == head.count);
   assign out_data = tls_pkg::TDATA_BITS'({tok.len, tok.start, tok.cls});
   assign pop = out_valid && out_ready && out_last;

   always_comb begin
      idx_in = idx_ff;
      if (out_valid && out_ready) begin
         idx_in = out_last ? '0 : idx_ff + tls_pkg::QPTR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/token_lexer_stream.sv @@
// Token lexer top level: source bytes in, token transactions out.
// Depends on tls_pkg, tls_front, tls_queue, tls_back and assert_macros.svh.
//
// One source byte (or an end-of-input mark) is taken every cycle. Each byte
// is scanned in the cycle it is accepted, including any rescan of backed-off
// number suffix bytes, and yields a bundle of zero to four tokens that goes
// into a four-bundle queue. The output side delivers one token per cycle while
// rsp_tready is high, from the head of that queue, with tlast on the last token
// caused by an input transaction. The input stalls only while the queue holds
// four bundles, so new bytes are taken while earlier tokens still drain.
// After an unknown byte the lexer stays in error until reset: bytes give no
// tokens, but end of input still gives an end-of-file token.
`include "assert_macros.svh"

module token_lexer_stream (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] source_byte
   input  logic [0:0]                      req_tuser,  // [0] kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] token_class, [35:4] start_offset, [51:36] token_length, rest zero
   output logic [tls_pkg::TDATA_BITS-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   tls_pkg::queue_status_type          q_status;
   tls_pkg::bundle_type                push_bundle;
   tls_pkg::bundle_type                head;
   logic                               push;
   logic                               pop;
   logic [tls_pkg::QLVL_BITS-1:0]      q_level;

   tls_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_kind  (req_tuser[0]),
      .in_byte  (req_tdata),
      .in_ready (req_tready),
      .q_status (q_status),
      .push     (push),
      .bundle   (push_bundle)
   );

   tls_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status),
      .level       (q_level)
   );

   tls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   `ASSERT_NEVER(a_queue_level, clock, reset, q_level > tls_pkg::QLVL_BITS'(tls_pkg::QUEUE_DEPTH), "token queue overfilled")
   `ASSERT_PROP(a_stall_has_output, clock, reset, !req_tready |-> rsp_tvalid, "input stalled with no token waiting")
   `ASSERT_PROP(a_eof_queued, clock, reset, (req_tvalid && req_tready && req_tuser[0]) |=> rsp_tvalid, "end of input gave no token")
   `ASSERT_NEVER(a_empty_bundle, clock, reset, push && push_bundle.count == '0, "empty bundle pushed")

endmodule
